// ----- src/rlma_pkg.sv -----
// Shared constants, types and item formats of the rate-limited moving average.
package rlma_pkg;

   localparam int CHANNELS     = 16;
   localparam int WINDOW       = 9;
   localparam int SAMPLE_WIDTH = 20;

   localparam int CHAN_WIDTH     = 4;
   localparam int CHAN_IDX_WIDTH = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int STEP_WIDTH     = 19;
   localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(80);

   localparam int SLOT_WIDTH  = $clog2(WINDOW);
   localparam int RING_DEPTH  = CHANNELS * WINDOW;
   localparam int ADDR_WIDTH  = $clog2(RING_DEPTH);
   localparam int CLAMP_WIDTH = SAMPLE_WIDTH + 2;
   localparam int TOTAL_WIDTH = SAMPLE_WIDTH + $clog2(WINDOW);

   // Division by WINDOW as a multiply by a rounded-up reciprocal. With the
   // shift below the quotient is exact for every magnitude the total can take.
   localparam int DIV_SHIFT  = TOTAL_WIDTH + $clog2(WINDOW);
   localparam int MULT_WIDTH = TOTAL_WIDTH + 1;
   localparam int PROD_WIDTH = TOTAL_WIDTH + MULT_WIDTH;
   localparam logic [MULT_WIDTH-1:0] DIV_MULT =
      MULT_WIDTH'(((longint'(1) << DIV_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW));

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [CHAN_WIDTH-1:0]          channel;
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic [SLOT_WIDTH-1:0]          slot;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_push_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

endpackage

// ----- src/rlma_req_if.sv -----
// Request channel: a channel number and a raw sample with a valid/ready handshake.
interface rlma_req_if import rlma_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [CHAN_WIDTH-1:0]          channel;
   logic signed [SAMPLE_WIDTH-1:0] sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink (input valid, input channel, input sample, output ready);
endinterface

// ----- src/rlma_rsp_if.sv -----
// Response channel: a channel number and its window average with a valid/ready handshake.
interface rlma_rsp_if import rlma_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic [CHAN_WIDTH-1:0]          channel_out;
   logic signed [SAMPLE_WIDTH-1:0] average;

   modport source (output valid, output channel_out, output average, input ready);
   modport sink (input valid, input channel_out, input average, output ready);
endinterface

// ----- src/rlma_front.sv -----
// Front end: accepts requests, drops unknown channels and assigns each sample its ring slot.
module rlma_front import rlma_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rlma_req_if.sink   req,
   input  logic       q_full,
   output q_push_type push
);

   logic [SLOT_WIDTH-1:0]     slot_ff [CHANNELS];
   logic [CHAN_IDX_WIDTH-1:0] idx;
   logic                      accept;
   logic                      in_range;
   logic [SLOT_WIDTH-1:0]     slot_in;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign in_range  = int'(req.channel) < CHANNELS;
   assign idx       = req.channel[CHAN_IDX_WIDTH-1:0];

   always_comb begin
      if (int'(slot_ff[idx]) == WINDOW - 1) begin
         slot_in = '0;
      end else begin
         slot_in = slot_ff[idx] + SLOT_WIDTH'(1);
      end
   end

   assign push.valid        = accept && in_range;
   assign push.item.channel = req.channel;
   assign push.item.sample  = req.sample;
   assign push.item.slot    = slot_ff[idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            slot_ff[c] <= '0;
         end
      end else if (push.valid) begin
         slot_ff[idx] <= slot_in;
      end
   end

endmodule

// ----- src/rlma_queue.sv -----
// Short request queue that lets the front end and the back end stall independently.
module rlma_queue import rlma_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_push_type push,
   input  logic       pop,
   output q_head_type head,
   output logic       full
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = count_ff == QCNT_WIDTH'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop  = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ----- src/rlma_back.sv -----
// Back end: ring read, slew limiting and total update, then division by the window length.
module rlma_back import rlma_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [STEP_WIDTH-1:0] max_step,
   input  q_head_type            head,
   output logic                  pop,
   rlma_rsp_if.source            rsp
);

   // Ring storage; an entry not written since reset reads as zero.
   logic signed [SAMPLE_WIDTH-1:0] ring_ff [RING_DEPTH];
   logic                           ring_vld_ff [RING_DEPTH];

   // Per-channel state.
   logic signed [SAMPLE_WIDTH-1:0] last_ff [CHANNELS];
   logic signed [TOTAL_WIDTH-1:0]  total_ff [CHANNELS];
   logic                           primed_ff [CHANNELS];

   logic                  advance;
   logic [ADDR_WIDTH-1:0] rd_addr;

   // Stage 1: ring read.
   logic                           s1_valid_ff;
   logic [CHAN_WIDTH-1:0]          s1_ch_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff;
   logic [ADDR_WIDTH-1:0]          s1_addr_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_rd_data_ff;
   logic                           s1_rd_vld_ff;

   // Stage 2: limiting and total update.
   logic [CHAN_IDX_WIDTH-1:0]      s1_idx;
   logic signed [SAMPLE_WIDTH-1:0] old_val;
   logic signed [CLAMP_WIDTH-1:0]  prev_ext, step_ext, x_ext, hi, lo;
   logic signed [SAMPLE_WIDTH-1:0] kept;
   logic signed [TOTAL_WIDTH-1:0]  s2_total_in;
   logic                           s2_valid_ff;
   logic [CHAN_WIDTH-1:0]          s2_ch_ff;
   logic signed [TOTAL_WIDTH-1:0]  s2_total_ff;

   // Stage 3: magnitude.
   logic                   s3_valid_ff;
   logic [CHAN_WIDTH-1:0]  s3_ch_ff;
   logic                   s3_neg_ff;
   logic [TOTAL_WIDTH-1:0] s3_mag_ff;

   // Stage 4: reciprocal multiply.
   logic                  s4_valid_ff;
   logic [CHAN_WIDTH-1:0] s4_ch_ff;
   logic                  s4_neg_ff;
   logic [PROD_WIDTH-1:0] s4_prod_ff;

   // Stage 5: output register.
   logic [SAMPLE_WIDTH-1:0]        quot;
   logic signed [SAMPLE_WIDTH-1:0] s5_avg_in;
   logic                           s5_valid_ff;
   logic [CHAN_WIDTH-1:0]          s5_ch_ff;
   logic signed [SAMPLE_WIDTH-1:0] s5_avg_ff;

   assign advance = !s5_valid_ff || rsp.ready;
   assign pop     = advance && head.valid;
   assign rd_addr = ADDR_WIDTH'(int'(head.item.channel) * WINDOW + int'(head.item.slot));

   // A slot is rewritten only WINDOW requests of its channel later, so the read in
   // stage 1 never meets the write of the same entry in stage 2.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_rd_data_ff <= ring_ff[rd_addr];
         if (s1_valid_ff) begin
            ring_ff[s1_addr_ff] <= kept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_vld_ff[i] <= 1'b0;
         end
         s1_rd_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_rd_vld_ff <= ring_vld_ff[rd_addr];
         if (s1_valid_ff) begin
            ring_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ch_ff     <= head.item.channel;
         s1_sample_ff <= head.item.sample;
         s1_addr_ff   <= rd_addr;
      end
   end

   assign s1_idx   = s1_ch_ff[CHAN_IDX_WIDTH-1:0];
   assign old_val  = s1_rd_vld_ff ? s1_rd_data_ff : '0;
   assign prev_ext = CLAMP_WIDTH'(last_ff[s1_idx]);
   assign step_ext = signed'(CLAMP_WIDTH'(max_step));
   assign x_ext    = CLAMP_WIDTH'(s1_sample_ff);
   assign hi       = prev_ext + step_ext;
   assign lo       = prev_ext - step_ext;

   always_comb begin
      kept = s1_sample_ff;
      if (primed_ff[s1_idx]) begin
         if (x_ext > hi) begin
            kept = hi[SAMPLE_WIDTH-1:0];
         end else if (x_ext < lo) begin
            kept = lo[SAMPLE_WIDTH-1:0];
         end
      end
   end

   assign s2_total_in = total_ff[s1_idx] - TOTAL_WIDTH'(old_val) + TOTAL_WIDTH'(kept);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            total_ff[c]  <= '0;
            primed_ff[c] <= 1'b0;
         end
      end else if (advance && s1_valid_ff) begin
         total_ff[s1_idx]  <= s2_total_in;
         primed_ff[s1_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         last_ff[s1_idx] <= kept;
      end
   end

   assign quot      = s4_prod_ff[DIV_SHIFT +: SAMPLE_WIDTH];
   assign s5_avg_in = s4_neg_ff ? -signed'(quot) : signed'(quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ch_ff    <= s1_ch_ff;
         s2_total_ff <= s2_total_in;
         s3_ch_ff    <= s2_ch_ff;
         s3_neg_ff   <= s2_total_ff[TOTAL_WIDTH-1];
         s3_mag_ff   <= s2_total_ff[TOTAL_WIDTH-1] ? unsigned'(-s2_total_ff)
                                                   : unsigned'(s2_total_ff);
         s4_ch_ff    <= s3_ch_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_prod_ff  <= PROD_WIDTH'(s3_mag_ff) * PROD_WIDTH'(DIV_MULT);
         s5_ch_ff    <= s4_ch_ff;
         s5_avg_ff   <= s5_avg_in;
      end
   end

   assign rsp.valid       = s5_valid_ff;
   assign rsp.channel_out = s5_ch_ff;
   assign rsp.average     = s5_avg_ff;

endmodule

// ----- src/rate_limited_moving_average.sv -----
// Top level of the slew-limited moving average over interleaved sensor channels.
//
// Requests arrive on req_stream, each carrying a channel number and a signed Q16.4
// sample. Every accepted request for a known channel gives exactly one response on
// rsp_stream with the same channel and the nine-sample window average, in order.
// A request for a channel beyond the configured count is dropped without a response.
// The user must write the limit max_step via csr_wr_en and csr_wr_data while idle (not enforced).
//
// A request goes through the queue, ring read, limiting, magnitude, multiply and
// output registers. Throughput is one request per cycle on any channel mix while the
// receiver is ready: per-channel state sits in registers updated in a single stage,
// so back-to-back requests for the same channel need no extra wait.
//
// Reset clears all rings, totals, slots and primed flags at once and sets max_step
// to 5.0 (80 in Q16.4). The block accepts requests in the cycle after reset ends.
//
// When the receiver stalls, the output register holds its response and the back
// pipeline freezes; the two-entry queue then fills and req_stream.ready drops.
module rate_limited_moving_average import rlma_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rlma_req_if.sink              req_stream,
   rlma_rsp_if.source            rsp_stream,
   input  logic                  csr_wr_en,
   input  logic [STEP_WIDTH-1:0] csr_wr_data
);

   logic [STEP_WIDTH-1:0] max_step_ff;
   q_push_type            push;
   q_head_type            head;
   logic                  q_full;
   logic                  pop;

   // The limit register; the user must write it only while no request is in flight (not enforced).
   always_ff @(posedge clock) begin
      if (reset) begin
         max_step_ff <= STEP_RESET;
      end else if (csr_wr_en) begin
         max_step_ff <= csr_wr_data;
      end
   end

   // The front end hands each request to the queue together with its ring slot.
   rlma_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_stream),
      .q_full (q_full),
      .push   (push)
   );

   rlma_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   // The back end limits the sample, updates the window and divides by nine.
   rlma_back u_back (
      .clock    (clock),
      .reset    (reset),
      .max_step (max_step_ff),
      .head     (head),
      .pop      (pop),
      .rsp      (rsp_stream)
   );

endmodule
